// ----- hw/rtl/qpil_pkg.sv -----
package qpil_pkg;

  // Table sizes and field widths
  localparam int LOOKUP_DEPTH = 256;
  localparam int RECORD_DEPTH = 256;
  localparam int LADDR_W      = $clog2(LOOKUP_DEPTH);
  localparam int RADDR_W      = $clog2(RECORD_DEPTH);
  localparam int CNT_W        = 9;
  localparam int ENTRY_W      = 9;
  localparam int FIDX_W       = 9;
  localparam int QID_W        = 32;
  localparam int SLOT_W       = 8;
  localparam int CMD_W        = 2;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // Remainder unit: bits retired per cycle
  localparam int MOD_STEP   = 4;
  localparam int MOD_CYCLES = QID_W / MOD_STEP;
  localparam int MODCNT_W   = $clog2(MOD_CYCLES);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_LOOKUP = 2'd0,
    CMD_WR_RECORD = 2'd1,
    CMD_FIND      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  // Register indexes on the configuration port
  localparam logic REG_LOOKUP_COUNT = 1'b0;
  localparam logic REG_RECORD_COUNT = 1'b1;

  // (a + 1) mod m, for a < m
  function automatic logic [LADDR_W-1:0] inc_mod(input logic [LADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0] m);
    logic [CNT_W-1:0] sum;
    sum = CNT_W'(a) + CNT_W'(1);
    if (sum >= m) begin
      inc_mod = '0;
    end else begin
      inc_mod = LADDR_W'(sum);
    end
  endfunction

  // (a + b) mod m, for a, b < m
  function automatic logic [LADDR_W-1:0] add_mod(input logic [LADDR_W-1:0] a,
                                                 input logic [LADDR_W-1:0] b,
                                                 input logic [CNT_W-1:0] m);
    logic [CNT_W:0] sum;
    logic [CNT_W:0] diff;
    sum  = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    diff = sum - (CNT_W+1)'(m);
    if (sum >= (CNT_W+1)'(m)) begin
      add_mod = LADDR_W'(diff);
    end else begin
      add_mod = LADDR_W'(sum);
    end
  endfunction

endpackage

// ----- hw/rtl/quadratic_probe_id_lookup_core.sv -----
// Table writes (cmd 0, 1) give no word out; cmd 3 is dropped.
// A find with lookup_count zero scans record ids in order from slot 0.
// A hashed find first takes query_id mod lookup_count (4 bits/cycle), then probes:
// each probe reads a lookup entry and, when it is valid, the record id it names.
// One item is in flight at a time; the result register frees the input side.
// Synchronous reset clears control and both counts; both tables stay undefined.
module quadratic_probe_id_lookup_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [qpil_pkg::PADDR_W-1:0]         paddr,
  input  logic [qpil_pkg::PDATA_W-1:0]         pwdata,
  output logic [qpil_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  // request channel
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [qpil_pkg::CMD_W-1:0]           cmd,
  input  logic [qpil_pkg::SLOT_W-1:0]          slot,
  input  logic signed [qpil_pkg::ENTRY_W-1:0]  lookup_value,
  input  logic [qpil_pkg::QID_W-1:0]           record_id_value,
  input  logic [qpil_pkg::QID_W-1:0]           query_id,
  // response channel
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic signed [qpil_pkg::FIDX_W-1:0]   found_index,
  output logic                                 probe_limit_hit
);
  import qpil_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MOD  = 8'b0000_0010,
    S_LRD  = 8'b0000_0100,
    S_LCHK = 8'b0000_1000,
    S_RCHK = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_SCMP = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] lookup_count;
  logic [CNT_W-1:0] record_count;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_count <= '0;
      record_count <= '0;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1])
        REG_LOOKUP_COUNT: lookup_count <= CNT_W'(pwdata);
        REG_RECORD_COUNT: record_count <= CNT_W'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1])
      REG_LOOKUP_COUNT: prdata = PDATA_W'(lookup_count);
      REG_RECORD_COUNT: prdata = PDATA_W'(record_count);
      default:          prdata = '0;
    endcase
  end

  // Counts beyond the table depth act as the depth
  logic [CNT_W-1:0] lcnt;
  logic [CNT_W-1:0] rcnt;

  assign lcnt = (lookup_count > CNT_W'(LOOKUP_DEPTH)) ? CNT_W'(LOOKUP_DEPTH) : lookup_count;
  assign rcnt = (record_count > CNT_W'(RECORD_DEPTH)) ? CNT_W'(RECORD_DEPTH) : record_count;

  // ---------------------------------------------------------------------
  // Request side: accept only while idle, one word at a time
  // ---------------------------------------------------------------------
  logic req_accept;
  logic is_find;

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign is_find    = req_accept && (cmd == CMD_FIND);

  // ---------------------------------------------------------------------
  // Tables
  // ---------------------------------------------------------------------
  logic               lk_we;
  logic               rec_we;
  logic [LADDR_W-1:0] lk_raddr;
  logic [RADDR_W-1:0] rec_raddr;
  logic [ENTRY_W-1:0] lk_rdata;
  logic [QID_W-1:0]   rec_rdata;

  assign lk_we  = req_accept && (cmd == CMD_WR_LOOKUP) && (32'(slot) < LOOKUP_DEPTH);
  assign rec_we = req_accept && (cmd == CMD_WR_RECORD) && (32'(slot) < RECORD_DEPTH);

  qpil_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOOKUP_DEPTH)
  ) u_lookup_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (LADDR_W'(slot)),
    .wdata (lookup_value),
    .re    (state == S_LRD),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  qpil_ram #(
    .WIDTH (QID_W),
    .DEPTH (RECORD_DEPTH)
  ) u_record_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (RADDR_W'(slot)),
    .wdata (record_id_value),
    .re    ((state == S_SCAN) || (state == S_LCHK)),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  // ---------------------------------------------------------------------
  // Hash start position: query_id mod lookup_count
  // ---------------------------------------------------------------------
  logic               mod_done;
  logic [LADDR_W-1:0] mod_rem;

  qpil_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (is_find && (lcnt != '0)),
    .dividend  (query_id),
    .divisor   (lcnt),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // ---------------------------------------------------------------------
  // Probe datapath
  // pos: current slot; sq: n^2 mod L; step: (2n+1) mod L; n: probe number.
  // Squares advance by adding odd steps, so no multiply is needed.
  // ---------------------------------------------------------------------
  logic [QID_W-1:0]   query;
  logic [LADDR_W-1:0] pos;
  logic [LADDR_W-1:0] sq;
  logic [LADDR_W-1:0] step;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   k;
  logic [RADDR_W-1:0] entry;
  logic [FIDX_W-1:0]  res_index;
  logic               res_limit;

  logic [LADDR_W-1:0] pos_adv;
  logic [LADDR_W-1:0] sq_adv;
  logic [LADDR_W-1:0] step_adv;
  logic               last_probe;
  logic               ent_empty;
  logic               ent_ok;
  logic               rec_hit;
  logic               out_load;

  assign pos_adv    = add_mod(pos, sq, lcnt);
  assign sq_adv     = add_mod(sq, step, lcnt);
  assign step_adv   = inc_mod(inc_mod(step, lcnt), lcnt);
  assign last_probe = (n == lcnt);

  // All ones is the empty marker; negative or out-of-range entries are misses
  assign ent_empty = (lk_rdata == '1);
  assign ent_ok    = !lk_rdata[ENTRY_W-1] && (lk_rdata < rcnt);
  assign rec_hit   = (rec_rdata == query);

  assign lk_raddr  = pos;
  assign rec_raddr = (state == S_SCAN) ? k[RADDR_W-1:0] : lk_rdata[RADDR_W-1:0];

  assign out_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (is_find) begin
            if (lcnt != '0) begin
              state <= S_MOD;
            end else if (rcnt == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_LRD;
          end
        end
        S_LRD:  state <= S_LCHK;
        S_LCHK: begin
          if (ent_empty) begin
            state <= S_DONE;
          end else if (ent_ok) begin
            state <= S_RCHK;
          end else if (last_probe) begin
            state <= S_DONE;
          end else begin
            state <= S_LRD;
          end
        end
        S_RCHK: begin
          if (rec_hit || last_probe) begin
            state <= S_DONE;
          end else begin
            state <= S_LRD;
          end
        end
        S_SCAN: state <= S_SCMP;
        S_SCMP: begin
          if (rec_hit || ((k + CNT_W'(1)) == rcnt)) begin
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers of the search
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        query     <= query_id;
        k         <= '0;
        res_index <= '1;
        res_limit <= 1'b0;
      end
      S_MOD: begin
        // first probe: n = 1, n^2 = 1, next odd step = 3, all mod L
        pos  <= mod_rem;
        sq   <= inc_mod('0, lcnt);
        step <= inc_mod(inc_mod(inc_mod('0, lcnt), lcnt), lcnt);
        n    <= CNT_W'(1);
      end
      S_LCHK: begin
        entry <= lk_rdata[RADDR_W-1:0];
        if (!ent_empty && !ent_ok) begin
          if (last_probe) begin
            res_limit <= 1'b1;
          end else begin
            n    <= n + CNT_W'(1);
            pos  <= pos_adv;
            sq   <= sq_adv;
            step <= step_adv;
          end
        end
      end
      S_RCHK: begin
        if (rec_hit) begin
          res_index <= FIDX_W'(entry);
        end else if (last_probe) begin
          res_limit <= 1'b1;
        end else begin
          n    <= n + CNT_W'(1);
          pos  <= pos_adv;
          sq   <= sq_adv;
          step <= step_adv;
        end
      end
      S_SCMP: begin
        if (rec_hit) begin
          res_index <= FIDX_W'(k);
        end else begin
          k <= k + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Result register: holds the word until the consumer takes it
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found_index     <= res_index;
      probe_limit_hit <= res_limit;
    end
  end

endmodule

// ----- hw/rtl/qpil_ram.sv -----
module qpil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/qpil_mod.sv -----
module qpil_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qpil_pkg::QID_W-1:0]  dividend,
  input  logic [qpil_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [qpil_pkg::LADDR_W-1:0] remainder
);
  import qpil_pkg::*;

  logic                busy;
  logic [MODCNT_W-1:0] cnt;
  logic [QID_W-1:0]    dvd;
  logic [CNT_W-1:0]    divr;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    rem_next;

  // Restoring remainder, MOD_STEP dividend bits per cycle, MSB first
  always_comb begin
    logic [CNT_W:0] r2;
    rem_next = rem;
    for (int i = 0; i < MOD_STEP; i++) begin
      r2 = {rem_next, dvd[QID_W-1-i]};
      if (r2 >= (CNT_W+1)'(divr)) begin
        r2 = r2 - (CNT_W+1)'(divr);
      end
      rem_next = CNT_W'(r2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + MODCNT_W'(1);
        if (cnt == MODCNT_W'(MOD_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      divr <= divisor;
      rem  <= '0;
    end else if (busy) begin
      dvd <= dvd << MOD_STEP;
      rem <= rem_next;
    end
  end

  assign remainder = LADDR_W'(rem);

endmodule
